### design/ttps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types and constants of the transposition table probe/store block.
// ----------------------------------------------------------------------------
package ttps_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 128;
  localparam int KEY_W       = 64;
  localparam int CNT_W       = 32;
  localparam int USED_W      = 17;

  // Action codes carried on the input tuser bit.
  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_STORE = 1'b1;

  // Bound kinds; the fourth code means nothing and a store carrying it is dropped.
  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  // Input item as packed on in_tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic [4:0]         pad;
    logic signed [15:0] window_high;
    logic signed [15:0] window_low;
    logic [9:0]         insert_ply;
    logic [6:0]         search_depth;
    logic [15:0]        new_move;
    logic signed [15:0] new_score;
    logic [1:0]         bound_kind;
    logic [63:0]        pos_key;
  } in_item_t;

  // Result item as packed on out_tdata, last declared field in the lowest bits.
  typedef struct packed {
    logic [3:0]         pad;
    logic [31:0]        collision_total;
    logic [16:0]        used_total;
    logic [31:0]        hit_total;
    logic [6:0]         found_depth;
    logic [1:0]         found_kind;
    logic [15:0]        found_move;
    logic signed [15:0] found_score;
    logic               score_usable;
    logic               hit;
  } result_t;

  // Slot payload held beside the key store.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [6:0]         depth;
    logic [9:0]         ply;
  } payload_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic capture;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } stat_t;

endpackage

### design/ttps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_ctrl
// Controller: clearing sweep after reset, then item accept and commit.
// ----------------------------------------------------------------------------
module ttps_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  ttps_pkg::stat_t stat,
  output ttps_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // The slot update and the counters move together with the result load.
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

### design/ttps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttps_dp
// Datapath: key and payload stores, probe test, replacement rules, counters.
// ----------------------------------------------------------------------------
module ttps_dp #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ttps_pkg::cmd_t                   cmd,
  output ttps_pkg::stat_t                  stat,
  input  logic [ttps_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ttps_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [ttps_pkg::KEY_W-1:0] key_mem [TABLE_ENTRIES];
  ttps_pkg::payload_t         pl_mem  [TABLE_ENTRIES];

  ttps_pkg::in_item_t         in_item;
  logic [IDX_W-1:0]           in_idx;

  ttps_pkg::in_item_t         item_r;
  logic                       action_r;
  logic [IDX_W-1:0]           idx_r;
  logic [ttps_pkg::KEY_W-1:0] rd_key_r;
  ttps_pkg::payload_t         rd_pl_r;
  logic [IDX_W-1:0]           clr_addr_r;

  logic [ttps_pkg::CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [ttps_pkg::USED_W-1:0] used_cnt_r, used_cnt_nxt;
  logic [ttps_pkg::CNT_W-1:0]  coll_cnt_r, coll_cnt_nxt;

  logic               out_tvalid_r;
  ttps_pkg::result_t  out_res_r;
  ttps_pkg::result_t  res;

  logic               key_nz, slot_empty, same_key, store_ok, is_store;
  logic               later, deeper, not_shallower, merge_wr;
  logic               key_we, pl_we, used_inc, coll_inc;
  logic               probe_hit, usable, bound_ok;
  logic [9:0]         wr_ply;
  ttps_pkg::payload_t wr_pl;

  assign in_item = ttps_pkg::in_item_t'(in_tdata);
  // A mask with the entry count less one always lands below the entry count.
  assign in_idx  = in_item.pos_key[IDX_W-1:0] & LAST_IDX;

  assign stat.clear_last = (clr_addr_r == LAST_IDX);
  assign stat.out_free   = !out_tvalid_r || out_tready;

  // Item capture and the registered store reads.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r   <= in_item;
      action_r <= in_tuser;
      idx_r    <= in_idx;
      rd_key_r <= key_mem[in_idx];
      rd_pl_r  <= pl_mem[in_idx];
    end
  end

  // Key store: zeroed by the sweep, then written on fill or replacement.
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      key_mem[clr_addr_r] <= '0;
    end else if (cmd.commit && key_we) begin
      key_mem[idx_r] <= item_r.pos_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && pl_we) begin
      pl_mem[idx_r] <= wr_pl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_addr_r <= stat.clear_last ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_comb begin
    is_store      = (action_r == ttps_pkg::ACT_STORE);
    key_nz        = (item_r.pos_key != '0);
    slot_empty    = (rd_key_r == '0);
    same_key      = (rd_key_r == item_r.pos_key);
    store_ok      = is_store && key_nz && (item_r.bound_kind <= ttps_pkg::KIND_UPPER);
    later         = (item_r.insert_ply > rd_pl_r.ply);
    deeper        = (item_r.search_depth > rd_pl_r.depth);
    not_shallower = (item_r.search_depth >= rd_pl_r.depth);

    merge_wr = (item_r.bound_kind == ttps_pkg::KIND_EXACT) ||
               ((item_r.bound_kind == ttps_pkg::KIND_LOWER) &&
                (rd_pl_r.kind == ttps_pkg::KIND_LOWER) &&
                (rd_pl_r.score < item_r.new_score)) ||
               ((item_r.bound_kind == ttps_pkg::KIND_UPPER) &&
                (rd_pl_r.kind == ttps_pkg::KIND_UPPER) &&
                (rd_pl_r.score > item_r.new_score)) ||
               ((item_r.bound_kind == ttps_pkg::KIND_LOWER) &&
                (rd_pl_r.kind == ttps_pkg::KIND_UPPER));

    key_we   = 1'b0;
    pl_we    = 1'b0;
    used_inc = 1'b0;
    coll_inc = 1'b0;
    wr_ply   = rd_pl_r.ply;
    if (store_ok) begin
      if (slot_empty) begin
        key_we   = 1'b1;
        pl_we    = 1'b1;
        used_inc = 1'b1;
        wr_ply   = item_r.insert_ply;
      end else if (!same_key) begin
        // A colliding overwrite keeps the ply already in the slot.
        coll_inc = 1'b1;
        if (later || deeper) begin
          key_we = 1'b1;
          pl_we  = 1'b1;
        end
      end else if (later) begin
        pl_we  = 1'b1;
        wr_ply = item_r.insert_ply;
      end else if (not_shallower && merge_wr) begin
        pl_we = 1'b1;
      end
    end

    wr_pl.kind  = item_r.bound_kind;
    wr_pl.score = item_r.new_score;
    wr_pl.move  = item_r.new_move;
    wr_pl.depth = item_r.search_depth;
    wr_pl.ply   = wr_ply;

    probe_hit = !is_store && key_nz && same_key;
    case (rd_pl_r.kind)
      ttps_pkg::KIND_EXACT: bound_ok = 1'b1;
      ttps_pkg::KIND_LOWER: bound_ok = (rd_pl_r.score >= item_r.window_high);
      ttps_pkg::KIND_UPPER: bound_ok = (rd_pl_r.score <= item_r.window_low);
      default:              bound_ok = 1'b0;
    endcase
    usable = probe_hit && (rd_pl_r.depth >= item_r.search_depth) && bound_ok;

    hit_cnt_nxt  = hit_cnt_r + ttps_pkg::CNT_W'(probe_hit);
    used_cnt_nxt = used_cnt_r + ttps_pkg::USED_W'(used_inc);
    coll_cnt_nxt = coll_cnt_r + ttps_pkg::CNT_W'(coll_inc);

    res                 = '0;
    res.hit             = probe_hit;
    res.score_usable    = usable;
    res.found_score     = usable ? rd_pl_r.score : '0;
    res.found_move      = probe_hit ? rd_pl_r.move : '0;
    res.found_kind      = probe_hit ? rd_pl_r.kind : '0;
    res.found_depth     = probe_hit ? rd_pl_r.depth : '0;
    res.hit_total       = hit_cnt_nxt;
    res.used_total      = used_cnt_nxt;
    res.collision_total = coll_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      used_cnt_r <= '0;
      coll_cnt_r <= '0;
    end else if (cmd.commit) begin
      hit_cnt_r  <= hit_cnt_nxt;
      used_cnt_r <= used_cnt_nxt;
      coll_cnt_r <= coll_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = ttps_pkg::OUT_TDATA_W'(out_res_r);

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid_r || out_tready))
    else $error("result committed while the output register still held an item");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented on the next cycle");

  a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(hit_cnt_r) && $stable(coll_cnt_r))
    else $error("counter moved without a commit");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= ttps_pkg::USED_W'(TABLE_ENTRIES))
    else $error("used count exceeds the number of slots");

  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_en |-> !cmd.capture && !cmd.commit)
    else $error("item handled during the clearing sweep");
`endif

endmodule

### design/transposition_table_probe_store.sv
`timescale 1ns / 1ps
// Flow: an accepted item is captured together with its slot read; its result is loaded
// into the output register and shown on out_tvalid at the commit that follows, which
// waits while that register still holds a result not yet taken on out_tready. No new
// item is accepted until the last one has been committed.
// Reset: synchronous, active low; afterwards a sweep zeroes the key store, one slot per
// cycle, and in_tready stays low until it ends.
// ----------------------------------------------------------------------------
// transposition_table_probe_store
// Direct-mapped transposition table with probe and store items on one stream.
// ----------------------------------------------------------------------------
module transposition_table_probe_store #(
  parameter int TABLE_ENTRIES = ttps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata, lowest bit up: pos_key[63:0], bound_kind[65:64],
  // new_score[81:66], new_move[97:82], search_depth[104:98],
  // insert_ply[114:105], window_low[130:115], window_high[146:131], zero pad.
  input  logic [ttps_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: action (0 probe, 1 store).
  input  logic                             in_tuser,
  // Result item stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata, lowest bit up: hit[0], score_usable[1], found_score[17:2],
  // found_move[33:18], found_kind[35:34], found_depth[42:36],
  // hit_total[74:43], used_total[91:75], collision_total[123:92], zero pad.
  output logic [ttps_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // The controller sequences the clearing sweep and then alternates between
  // accepting an item (which also starts the slot read) and committing it.
  // The commit writes the slot, moves the counters and loads the output
  // register in the same cycle, and waits only if that register is still full.
  ttps_pkg::cmd_t  cmd;
  ttps_pkg::stat_t stat;

  ttps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the key store (cleared after reset, zero meaning an
  // empty slot) and the payload store, which is never cleared: its entries
  // are only looked at once the matching key is nonzero, so every entry read
  // has been written before.
  ttps_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
